/* rtl/assert_macros.svh */
// Assertion helpers shared by the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/beg_pkg.sv */
package beg_pkg;
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRIG  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_LIN   = 2'd1;
    localparam logic [1:0] MODE_GEO   = 2'd2;
    localparam logic [1:0] MODE_DEF   = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_START = 2'd1;
    localparam logic [1:0] ERR_GEO   = 2'd2;

    localparam logic [0:0] REG_COUNT = 1'd0;
    localparam logic [0:0] REG_MODE  = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the input transaction
        logic write_pt;  // write the breakpoint tables
        logic trig;      // start at the requested point
        logic tick;      // count one sample and classify
        logic seek;      // advance one point while behind the count
        logic load;      // load segment at the current point
        logic div_start; // begin the step division
        logic div_step;  // one division iteration
        logic div_done;  // finish the division
        logic advance;   // add step or multiply
        logic result;    // present the result
    } beg_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_ok;     // trigger index within count
        logic       running;
        logic       stop;       // count reached the last time
        logic       boundary;   // count hit the next point
        logic       seek_more;  // another point lies behind the count
        logic       need_div;   // segment is linear with a forward time
        logic       div_last;   // final division iteration
    } beg_sts_t;
endpackage

/* rtl/beg_if.sv */
interface beg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  point_index;
    logic [23:0] point_time;
    logic signed [31:0] point_value;
    logic [1:0]  point_mode;
    logic [31:0] point_ratio;
    modport source (output valid, op, point_index, point_time, point_value, point_mode,
                    point_ratio, input ready);
    modport sink (input valid, op, point_index, point_time, point_value, point_mode,
                  point_ratio, output ready);
endinterface

interface beg_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] envelope_value;
    logic        running;
    logic [3:0]  segment;
    logic [1:0]  error;
    modport source (output valid, envelope_value, running, segment, error, input ready);
    modport sink (input valid, envelope_value, running, segment, error, output ready);
endinterface

/* rtl/breakpoint_envelope_generator.sv */
// Breakpoint envelope generator.
// Input channel (in): one transaction carries op, point_index, point_time,
// point_value, point_mode and point_ratio. Op 0 writes a breakpoint, op 1
// triggers the envelope from a point, op 2 is one sample tick.
// Output channel (out): exactly one transaction per input transaction, with
// envelope_value (Q16.16), running, segment and error.
// Configuration: APB-style port, point_count at 0x0, default_mode at 0x4.
// Sequence: a write or a stopped tick goes straight to the result, a plain
// tick passes the seek state and a trigger loads its segment. A boundary tick
// also loads the next segment, seeking once per further skipped point; a
// linear segment load adds the serial step divider.
// One transaction is processed at a time; the next is accepted in the cycle
// after the result is registered, even while that result still waits in its
// output register. If the receiver stalls, the result holds and the
// controller waits before overwriting it, so the input stalls as well.
// Reset clears the envelope state and the registers (count 2, default mode
// linear); the breakpoint tables hold no defined contents until written.
module breakpoint_envelope_generator #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    beg_in_if.sink      in,
    beg_out_if.source   out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import beg_pkg::*;

    beg_cmd_t cmd;
    beg_sts_t sts;

    logic [4:0] count_reg;
    logic [1:0] dmode_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd2;
            dmode_reg <= MODE_LIN;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == REG_COUNT)
                count_reg <= pwdata[4:0];
            else
                dmode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_COUNT)
            prdata = {27'd0, count_reg};
        else
            prdata = {30'd0, dmode_reg};
    end

    beg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .out_valid(out.valid),
        .out_ready(out.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    beg_dp #(
        .MAX_POINTS(MAX_POINTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (in.op),
        .in_index      (in.point_index),
        .in_time       (in.point_time),
        .in_value      (in.point_value),
        .in_mode       (in.point_mode),
        .in_ratio      (in.point_ratio),
        .point_count   (count_reg),
        .default_mode  (dmode_reg),
        .envelope_value(out.envelope_value),
        .running       (out.running),
        .segment       (out.segment),
        .error         (out.error)
    );
endmodule

/* rtl/beg_ctrl.sv */
`include "assert_macros.svh"
module beg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  beg_pkg::beg_sts_t sts,
    output beg_pkg::beg_cmd_t cmd
);
    import beg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SEEK = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // The output register frees the controller: a new transaction may be
    // taken while the previous result waits; the next result waits until then.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_WRITE:
                    begin
                        cmd.write_pt = 1'b1;
                        state_next   = S_OUT;
                    end
                    OP_TRIG:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.trig   = 1'b1;
                            state_next = S_LOAD;
                        end
                        else
                            state_next = S_OUT;
                    end
                    OP_TICK:
                    begin
                        if (sts.running)
                        begin
                            cmd.tick   = 1'b1;
                            state_next = S_SEEK;
                        end
                        else
                            state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_SEEK:
            begin
                if (sts.stop)
                    state_next = S_OUT;
                else if (sts.boundary)
                begin
                    if (sts.seek_more)
                        cmd.seek = 1'b1;
                    else
                        state_next = S_LOAD;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.div_done = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE,
        "input ready outside idle")
    `ASSERT_NEXT(a_result_valid, clk, rst_n, cmd.result, out_valid_reg,
        "result not presented")
    `ASSERT_IMPL(a_div_in_div, clk, rst_n, cmd.div_step, state_reg == S_DIV,
        "division step outside division state")
endmodule

/* rtl/beg_dp.sv */
`include "assert_macros.svh"
module beg_dp #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  beg_pkg::beg_cmd_t cmd,
    output beg_pkg::beg_sts_t sts,
    input  logic [1:0]        in_op,
    input  logic [3:0]        in_index,
    input  logic [23:0]       in_time,
    input  logic [31:0]       in_value,
    input  logic [1:0]        in_mode,
    input  logic [31:0]       in_ratio,
    input  logic [4:0]        point_count,
    input  logic [1:0]        default_mode,
    output logic [31:0]       envelope_value,
    output logic              running,
    output logic [3:0]        segment,
    output logic [1:0]        error
);
    import beg_pkg::*;

    localparam int PB = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CB = $clog2(MAX_POINTS + 1);
    localparam int NB = (CB > 5) ? CB : 5;
    localparam logic [NB-1:0] MAXN = NB'(MAX_POINTS);
    localparam int DB = 34;   // value difference magnitude bits
    localparam int QB = 6;

    logic [TIME_BITS-1:0] time_mem  [MAX_POINTS];
    logic [31:0]          value_mem [MAX_POINTS];
    logic [1:0]           mode_mem  [MAX_POINTS];
    logic [31:0]          ratio_mem [MAX_POINTS];

    logic [1:0]  op_reg;
    logic [3:0]  idx_reg;
    logic [23:0] tim_reg;
    logic [31:0] val_reg;
    logic [1:0]  mod_reg;
    logic [31:0] rat_reg;

    logic [TIME_BITS-1:0] cnt_reg;
    logic [PB-1:0]        pt_reg;
    logic signed [31:0]   level_reg;
    logic signed [31:0]   step_reg;
    logic [1:0]           amode_reg;
    logic                 run_reg;
    logic [1:0]           err_reg;

    logic signed [31:0] out_val_reg;
    logic               out_run_reg;
    logic [3:0]         out_seg_reg;
    logic [1:0]         out_err_reg;

    logic [DB-1:0]        quo_reg, rem_reg, num_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic                 qneg_reg;
    logic [QB-1:0]        it_reg;

    // Effective point count, clamped to 2..MAX_POINTS.
    logic [NB-1:0] n_eff;
    always_comb
    begin
        n_eff = NB'(point_count);
        if (n_eff < NB'(2))
            n_eff = NB'(2);
        if (n_eff > MAXN)
            n_eff = MAXN;
    end

    logic [PB-1:0] last_p;
    assign last_p = PB'(n_eff - NB'(1));

    logic [NB-1:0] pt_ext, nxt_ext;
    logic [PB-1:0] nxt_p;
    logic          has_next;
    assign pt_ext   = NB'(pt_reg);
    assign nxt_ext  = pt_ext + NB'(1);
    assign has_next = nxt_ext < n_eff;
    assign nxt_p    = PB'(nxt_ext);

    logic [TIME_BITS-1:0] t_cur, t_nxt;
    logic signed [31:0]   v_cur, v_nxt;
    assign t_cur = time_mem[pt_reg];
    assign t_nxt = time_mem[nxt_p];
    assign v_cur = value_mem[pt_reg];
    assign v_nxt = value_mem[nxt_p];

    logic [1:0] rmode;
    always_comb
    begin
        rmode = mode_mem[pt_reg];
        if (rmode == MODE_DEF)
            rmode = default_mode;
        if (rmode == MODE_DEF)
            rmode = MODE_CONST;
    end

    logic geo_bad;
    assign geo_bad = (v_cur == 32'sd0) || (v_nxt == 32'sd0) || (v_cur[31] != v_nxt[31]);

    logic need_div;
    assign need_div = has_next && (rmode == MODE_LIN) && (t_nxt > t_cur);

    logic [NB-1:0] idx_ext;
    assign idx_ext = NB'(idx_reg);

    // Saturating linear add.
    logic signed [32:0] lin_sum;
    logic signed [31:0] lin_sat;
    assign lin_sum = {level_reg[31], level_reg} + {step_reg[31], step_reg};
    always_comb
    begin
        if (lin_sum > 33'sd2147483647)
            lin_sat = 32'sh7fffffff;
        else if (lin_sum < -33'sd2147483648)
            lin_sat = 32'sh80000000;
        else
            lin_sat = lin_sum[31:0];
    end

    // Geometric multiply on magnitude, rounding ties away from zero.
    logic [31:0] mag;
    logic [63:0] prod;
    logic [34:0] rnd;
    logic signed [31:0] geo_res;
    assign mag  = level_reg[31] ? (32'd0 - level_reg) : level_reg;
    assign prod = 64'(mag) * 64'(ratio_mem[pt_reg]);
    assign rnd  = 35'((prod + 64'd536870912) >> 30);
    always_comb
    begin
        if (!level_reg[31])
            geo_res = (rnd > 35'd2147483647) ? 32'sh7fffffff : rnd[31:0];
        else
            geo_res = (rnd > 35'd2147483648) ? 32'sh80000000 : 32'(35'd0 - rnd);
    end

    // Division: restoring, one quotient bit per step.
    logic signed [33:0] diff;
    assign diff = {{2{v_nxt[31]}}, v_nxt} - {{2{v_cur[31]}}, v_cur};
    logic [DB:0] trial;
    assign trial = {rem_reg, num_reg[DB-1]} - (DB+1)'(den_reg);

    logic [DB-1:0] qmag;
    logic signed [31:0] step_sat;
    assign qmag = quo_reg;
    always_comb
    begin
        if (!qneg_reg)
            step_sat = (qmag > DB'(32'h7fffffff)) ? 32'sh7fffffff : qmag[31:0];
        else
            step_sat = (qmag > DB'(33'h80000000)) ? 32'sh80000000 : 32'(DB'(0) - qmag);
    end

    logic [TIME_BITS-1:0] cnt_inc;
    assign cnt_inc = cnt_reg + TIME_BITS'(1);

    assign sts.op        = op_reg;
    assign sts.idx_ok    = idx_ext < n_eff;
    assign sts.running   = run_reg;
    assign sts.stop      = !run_reg;
    assign sts.boundary  = (err_reg == ERR_GEO);
    assign sts.seek_more = has_next && (cnt_reg >= t_nxt);
    assign sts.need_div  = need_div;
    assign sts.div_last  = it_reg == QB'(DB - 1);

    // The tick cycle raises err_reg to ERR_GEO as a private boundary flag;
    // the load cycle rewrites it with the segment's own code.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            idx_reg <= in_index;
            tim_reg <= in_time;
            val_reg <= in_value;
            mod_reg <= in_mode;
            rat_reg <= in_ratio;
        end
        if (cmd.write_pt && (int'(idx_reg) < MAX_POINTS))
        begin
            time_mem[PB'(idx_reg)]  <= TIME_BITS'(tim_reg);
            value_mem[PB'(idx_reg)] <= val_reg;
            mode_mem[PB'(idx_reg)]  <= mod_reg;
            ratio_mem[PB'(idx_reg)] <= rat_reg;
        end
        if (cmd.div_start)
        begin
            qneg_reg <= diff[33];
            num_reg  <= diff[33] ? DB'(34'sd0 - diff) : DB'(diff);
            den_reg  <= t_nxt - t_cur;
            rem_reg  <= '0;
            quo_reg  <= '0;
            it_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            it_reg  <= it_reg + QB'(1);
            num_reg <= {num_reg[DB-2:0], 1'b0};
            if (!trial[DB])
            begin
                rem_reg <= trial[DB-1:0];
                quo_reg <= {quo_reg[DB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DB-2:0], num_reg[DB-1]};
                quo_reg <= {quo_reg[DB-2:0], 1'b0};
            end
        end
        if (cmd.result)
        begin
            out_val_reg <= level_reg;
            out_run_reg <= run_reg;
            out_seg_reg <= 4'(pt_reg);
            out_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pt_reg    <= '0;
            level_reg <= '0;
            step_reg  <= '0;
            amode_reg <= MODE_CONST;
            run_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            if (cmd.capture)
                err_reg <= (in_op == OP_TRIG) ? ERR_START : ERR_NONE;
            if (cmd.trig)
            begin
                run_reg <= 1'b1;
                pt_reg  <= PB'(idx_reg);
                cnt_reg <= time_mem[PB'(idx_reg)];
            end
            if (cmd.tick)
            begin
                cnt_reg <= cnt_inc;
                err_reg <= ERR_NONE;
                if (cnt_inc >= time_mem[last_p])
                begin
                    level_reg <= value_mem[last_p];
                    run_reg   <= 1'b0;
                end
                else if (has_next && cnt_inc == t_nxt)
                    err_reg <= ERR_GEO;
            end
            if (cmd.seek)
                pt_reg <= nxt_p;
            if (cmd.load)
            begin
                level_reg <= v_cur;
                step_reg  <= '0;
                err_reg   <= ERR_NONE;
                amode_reg <= rmode;
                if (has_next && rmode == MODE_GEO && geo_bad)
                begin
                    err_reg   <= ERR_GEO;
                    amode_reg <= MODE_CONST;
                end
            end
            if (cmd.div_done)
                step_reg <= step_sat;
            if (cmd.advance)
            begin
                if (amode_reg == MODE_LIN)
                    level_reg <= lin_sat;
                else if (amode_reg == MODE_GEO)
                    level_reg <= geo_res;
            end
            if (cmd.result && op_reg != OP_TRIG && err_reg == ERR_START)
                err_reg <= ERR_NONE;
        end
    end

    assign envelope_value = out_val_reg;
    assign running        = out_run_reg;
    assign segment        = out_seg_reg;
    assign error          = out_err_reg;

    `ASSERT_IMPL(a_seek_bound, clk, rst_n, cmd.seek, has_next,
        "seek beyond the last point")
    `ASSERT_NEXT(a_trig_run, clk, rst_n, cmd.trig, run_reg,
        "trigger did not start the envelope")
endmodule
